### hw/rtl/fbp_pkg.sv
// Frame buffer pool package: sizes, operation codes and the stack memory request.
// No dependencies; used by the interfaces, the stack memory and the top level.
package fbp_pkg;

  localparam int NUM_BUFFERS = 16;
  localparam int ID_W        = $clog2(NUM_BUFFERS);
  localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);

  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_PUT   = 2'd1,
    OP_STORE = 2'd2,
    OP_LOAD  = 2'd3
  } op_e;

  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] waddr;
    logic [ID_W-1:0] wdata;
    logic            re;
    logic [ID_W-1:0] raddr;
  } stk_req_t;

endpackage

### hw/rtl/fbp_req_if.sv
// Request channel of the frame buffer pool: valid/ready plus operation and id.
// Depends on fbp_pkg.
interface fbp_req_if import fbp_pkg::*; ();
  logic            valid;
  logic            ready;
  op_e             op;
  logic [ID_W-1:0] buffer_id;

  modport source (output valid, output op, output buffer_id, input ready);
  modport sink   (input valid, input op, input buffer_id, output ready);
endinterface

### hw/rtl/fbp_rsp_if.sv
// Response channel of the frame buffer pool: valid/ready plus the result fields.
// Depends on fbp_pkg.
interface fbp_rsp_if import fbp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  out_id;
  logic             out_valid;
  logic             dropped_oldest;
  logic             op_error;
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] queued_count;

  modport source (output valid, output out_id, output out_valid, output dropped_oldest,
                  output op_error, output free_count, output queued_count, input ready);
  modport sink   (input valid, input out_id, input out_valid, input dropped_oldest,
                  input op_error, input free_count, input queued_count, output ready);
endinterface

### hw/rtl/fbp_stack_mem.sv
// Free stack storage: synchronous memory with registered read.
// Per-entry written flags make an unwritten entry read as its own index.
// Depends on fbp_pkg.
module fbp_stack_mem import fbp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stk_req_t        req_i,
  output logic [ID_W-1:0] rd_data_o
);

  logic [ID_W-1:0]        mem [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] written_q;
  logic [ID_W-1:0]        rd_mem_q;
  logic [ID_W-1:0]        rd_addr_q;
  logic                   rd_init_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_mem_q  <= mem[req_i.raddr];
      rd_addr_q <= req_i.raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_init_q <= 1'b0;
    end else begin
      if (req_i.re) begin
        rd_init_q <= !written_q[req_i.raddr];
      end
      if (req_i.we) begin
        written_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_init_q ? rd_addr_q : rd_mem_q;

endmodule

### hw/rtl/frame_buffer_pool_drop_oldest_core.sv
// Frame buffer pool with LIFO free stack and FIFO of filled buffers (drop oldest).
// Depends on fbp_pkg, fbp_req_if, fbp_rsp_if and fbp_stack_mem.
//
// Usage:
//   req_i carries one operation per transaction: get, put, store or load, with
//   the buffer id used by put and store. rsp_o returns exactly one transaction
//   per request: the id handed out (get/load), its valid flag, the drop flag
//   when get reclaimed the oldest filled buffer, the error flag for a put to a
//   full stack or a store to a full queue, and both counts after the operation.
//   The request is taken into the core registers together with the memory read;
//   the result moves into the output register once that register is free.
//   Requests do not overlap: after acceptance the stack or queue memory is
//   read synchronously, and no new request is taken until the result has
//   moved into the output register.
//   A finished response waits in the output register while the next request is
//   accepted; if the receiver still stalls, the following result waits in the
//   core and req_i.ready stays low until the output register frees up.
//   Reset: all ids free (stack entry i reads as id i through written flags, no
//   clearing pass), queue empty, no response pending. Usable right after reset.
module frame_buffer_pool_drop_oldest_core import fbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  fbp_req_if.sink   req_i,
  fbp_rsp_if.source rsp_o
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_RESULT
  } state_e;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_STACK,
    SRC_QUEUE
  } src_e;

  state_e           state_q;
  logic [CNT_W-1:0] free_top_q, free_top_d;
  logic [ID_W-1:0]  q_head_q, q_head_d;
  logic [CNT_W-1:0] q_len_q, q_len_d;
  src_e             src_q, src_d;
  logic             pend_valid_q, pend_valid_d;
  logic             pend_drop_q, pend_drop_d;
  logic             pend_err_q, pend_err_d;

  logic             rsp_valid_q;
  logic [ID_W-1:0]  rsp_id_q;
  logic             rsp_out_valid_q;
  logic             rsp_drop_q;
  logic             rsp_err_q;
  logic [CNT_W-1:0] rsp_free_q;
  logic [CNT_W-1:0] rsp_queued_q;

  stk_req_t         stk_req;
  logic [ID_W-1:0]  stk_rd_data;
  logic             q_we, q_re;
  logic [ID_W-1:0]  q_waddr;
  logic [ID_W-1:0]  q_mem [NUM_BUFFERS];
  logic [ID_W-1:0]  q_rd_q;
  logic [CNT_W:0]   q_pos_sum;
  logic [ID_W-1:0]  q_head_inc;
  logic             accept;
  logic             out_free;
  logic [ID_W-1:0]  res_id;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;

  assign q_pos_sum = (CNT_W+1)'(q_head_q) + (CNT_W+1)'(q_len_q);
  assign q_waddr   = (q_pos_sum >= (CNT_W+1)'(NUM_BUFFERS))
                   ? ID_W'(q_pos_sum - (CNT_W+1)'(NUM_BUFFERS)) : ID_W'(q_pos_sum);
  assign q_head_inc = (q_head_q == ID_W'(NUM_BUFFERS - 1)) ? '0 : q_head_q + 1'b1;

  always_comb begin
    free_top_d   = free_top_q;
    q_head_d     = q_head_q;
    q_len_d      = q_len_q;
    src_d        = SRC_NONE;
    pend_valid_d = 1'b0;
    pend_drop_d  = 1'b0;
    pend_err_d   = 1'b0;
    stk_req      = '0;
    q_we         = 1'b0;
    q_re         = 1'b0;
    if (accept) begin
      unique case (req_i.op)
        OP_GET: begin
          if (free_top_q != '0) begin
            free_top_d    = free_top_q - 1'b1;
            stk_req.re    = 1'b1;
            stk_req.raddr = ID_W'(free_top_q - 1'b1);
            src_d         = SRC_STACK;
            pend_valid_d  = 1'b1;
          end else if (q_len_q != '0) begin
            q_re         = 1'b1;
            q_head_d     = q_head_inc;
            q_len_d      = q_len_q - 1'b1;
            src_d        = SRC_QUEUE;
            pend_valid_d = 1'b1;
            pend_drop_d  = 1'b1;
          end
        end
        OP_PUT: begin
          if (free_top_q < CNT_W'(NUM_BUFFERS)) begin
            stk_req.we    = 1'b1;
            stk_req.waddr = ID_W'(free_top_q);
            stk_req.wdata = req_i.buffer_id;
            free_top_d    = free_top_q + 1'b1;
          end else begin
            pend_err_d = 1'b1;
          end
        end
        OP_STORE: begin
          if (q_len_q < CNT_W'(NUM_BUFFERS)) begin
            q_we    = 1'b1;
            q_len_d = q_len_q + 1'b1;
          end else begin
            pend_err_d = 1'b1;
          end
        end
        OP_LOAD: begin
          if (q_len_q != '0) begin
            q_re         = 1'b1;
            q_head_d     = q_head_inc;
            q_len_d      = q_len_q - 1'b1;
            src_d        = SRC_QUEUE;
            pend_valid_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  fbp_stack_mem u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (stk_req),
    .rd_data_o (stk_rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= req_i.buffer_id;
    end
    if (q_re) begin
      q_rd_q <= q_mem[q_head_q];
    end
  end

  always_comb begin
    unique case (src_q)
      SRC_STACK: res_id = stk_rd_data;
      SRC_QUEUE: res_id = q_rd_q;
      default:   res_id = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      free_top_q      <= CNT_W'(NUM_BUFFERS);
      q_head_q        <= '0;
      q_len_q         <= '0;
      src_q           <= SRC_NONE;
      pend_valid_q    <= 1'b0;
      pend_drop_q     <= 1'b0;
      pend_err_q      <= 1'b0;
      rsp_valid_q     <= 1'b0;
      rsp_id_q        <= '0;
      rsp_out_valid_q <= 1'b0;
      rsp_drop_q      <= 1'b0;
      rsp_err_q       <= 1'b0;
      rsp_free_q      <= '0;
      rsp_queued_q    <= '0;
    end else begin
      if (rsp_valid_q && rsp_o.ready && state_q != S_RESULT) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            free_top_q   <= free_top_d;
            q_head_q     <= q_head_d;
            q_len_q      <= q_len_d;
            src_q        <= src_d;
            pend_valid_q <= pend_valid_d;
            pend_drop_q  <= pend_drop_d;
            pend_err_q   <= pend_err_d;
            state_q      <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            rsp_valid_q     <= 1'b1;
            rsp_id_q        <= res_id;
            rsp_out_valid_q <= pend_valid_q;
            rsp_drop_q      <= pend_drop_q;
            rsp_err_q       <= pend_err_q;
            rsp_free_q      <= free_top_q;
            rsp_queued_q    <= q_len_q;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.out_id         = rsp_id_q;
  assign rsp_o.out_valid      = rsp_out_valid_q;
  assign rsp_o.dropped_oldest = rsp_drop_q;
  assign rsp_o.op_error       = rsp_err_q;
  assign rsp_o.free_count     = rsp_free_q;
  assign rsp_o.queued_count   = rsp_queued_q;

endmodule

### tb/tb_frame_buffer_pool_drop_oldest_core.sv
// Testbench for frame_buffer_pool_drop_oldest_core: drives get/put/store/load
// requests and checks every response against a cycle-free pool predictor.
// Depends on fbp_pkg, fbp_req_if, fbp_rsp_if and the core RTL.
`timescale 1ns / 1ps

module tb_frame_buffer_pool_drop_oldest_core;
  import fbp_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             vld;
    logic             drop;
    logic             err;
    logic [CNT_W-1:0] nfree;
    logic [CNT_W-1:0] nqueued;
  } pool_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  fbp_req_if req ();
  fbp_rsp_if rsp ();

  frame_buffer_pool_drop_oldest_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  // pool predictor state
  logic [ID_W-1:0] free_ids   [NUM_BUFFERS];
  logic [ID_W-1:0] filled_ids [NUM_BUFFERS];
  int              free_depth;
  int              filled_head;
  int              filled_len;
  logic [ID_W-1:0] last_given;

  pool_rsp_t pending_rsp[$];

  int  src_idle;
  int  snk_idle = 0;
  bit  hold_tgl = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  int  stall_cycles = 0;
  int  n_fail = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_drop = 0;
  int  n_err = 0;
  int  n_none = 0;

  function automatic void pool_reset();
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      free_ids[i]   = ID_W'(i);
      filled_ids[i] = '0;
    end
    free_depth  = NUM_BUFFERS;
    filled_head = 0;
    filled_len  = 0;
    last_given  = '0;
  endfunction

  function automatic logic [ID_W-1:0] filled_pop();
    logic [ID_W-1:0] id;
    id          = filled_ids[filled_head];
    filled_head = (filled_head == NUM_BUFFERS - 1) ? 0 : filled_head + 1;
    filled_len--;
    return id;
  endfunction

  function automatic pool_rsp_t pool_apply(input op_e op, input logic [ID_W-1:0] bid);
    pool_rsp_t r;
    r = '0;
    case (op)
      OP_GET: begin
        if (free_depth > 0) begin
          free_depth--;
          r.id  = free_ids[free_depth];
          r.vld = 1'b1;
        end else if (filled_len > 0) begin
          r.id   = filled_pop();
          r.vld  = 1'b1;
          r.drop = 1'b1;
        end
      end
      OP_PUT: begin
        if (free_depth < NUM_BUFFERS) begin
          free_ids[free_depth] = bid;
          free_depth++;
        end else begin
          r.err = 1'b1;
        end
      end
      OP_STORE: begin
        if (filled_len < NUM_BUFFERS) begin
          filled_ids[(filled_head + filled_len) % NUM_BUFFERS] = bid;
          filled_len++;
        end else begin
          r.err = 1'b1;
        end
      end
      default: begin
        if (filled_len > 0) begin
          r.id  = filled_pop();
          r.vld = 1'b1;
        end
      end
    endcase
    r.nfree   = CNT_W'(free_depth);
    r.nqueued = CNT_W'(filled_len);
    if (r.vld) last_given = r.id;
    return r;
  endfunction

  task automatic send_op(input op_e op, input logic [ID_W-1:0] bid);
    pool_rsp_t r;
    while ($urandom_range(99) < src_idle) begin
      req.valid     <= 1'b0;
      req.op        <= op_e'($urandom_range(3));
      req.buffer_id <= ID_W'($urandom_range(NUM_BUFFERS - 1));
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.op        <= op;
    req.buffer_id <= bid;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    r = pool_apply(op, bid);
    pending_rsp.push_back(r);
    n_sent++;
    if (r.drop) n_drop++;
    if (r.err) n_err++;
    if (!r.vld && (op == OP_GET || op == OP_LOAD)) n_none++;
  endtask

  task automatic drain_phase();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic test_directed();
    src_idle = 0;
    snk_idle <= 0;
    send_op(OP_PUT, 4'd5);         // stack full: rejected
    send_op(OP_LOAD, 4'd3);        // queue empty: no id
    send_op(OP_STORE, 4'd0);
    send_op(OP_STORE, 4'd15);
    repeat (NUM_BUFFERS) send_op(OP_GET, ID_W'($urandom_range(NUM_BUFFERS - 1)));
    send_op(OP_GET, 4'd0);         // reclaims oldest filled
    send_op(OP_GET, 4'd15);
    send_op(OP_GET, 4'd7);         // nothing left anywhere
    send_op(OP_STORE, 4'd9);
    send_op(OP_LOAD, 4'd6);
    drain_phase();
  endtask

  task automatic test_backpressure();
    src_idle = 0;
    snk_idle <= 0;
    hold_tgl <= ~hold_tgl;
    for (int i = 0; i < 40; i++)
      send_op(op_e'($urandom_range(3)), ID_W'($urandom_range(NUM_BUFFERS - 1)));
    drain_phase();
  endtask

  task automatic test_random(input int n_items, input int s_idle, input int r_idle);
    int              left;
    int              burst;
    int              pick;
    int              w[4];
    bit              flow;
    op_e             op;
    logic [ID_W-1:0] bid;
    src_idle = s_idle;
    snk_idle <= r_idle;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(60, 10);
      flow  = 1'b0;
      case ($urandom_range(5))
        0: begin w = '{25, 25, 25, 25}; flow = 1'b1; end
        1: w = '{60, 5, 25, 10};   // drain stack, reach drop-oldest
        2: w = '{10, 60, 15, 15};  // overfill stack
        3: w = '{15, 15, 60, 10};  // overfill queue
        4: w = '{15, 15, 15, 55};  // drain queue
        default: w = '{25, 25, 25, 25};
      endcase
      for (int k = 0; k < burst && left > 0; k++) begin
        pick = $urandom_range(99);
        if (pick < w[0]) op = OP_GET;
        else if (pick < w[0] + w[1]) op = OP_PUT;
        else if (pick < w[0] + w[1] + w[2]) op = OP_STORE;
        else op = OP_LOAD;
        bid = ID_W'($urandom_range(NUM_BUFFERS - 1));
        if (flow && $urandom_range(9) < 7) bid = last_given;
        send_op(op, bid);
        left--;
      end
    end
    drain_phase();
  endtask

  // response side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= HOLD_CYCLES;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    pool_rsp_t e;
    if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        n_fail++;
        $display("%0t: response with none expected, actual id %0d", $time, rsp.out_id);
      end else begin
        e = pending_rsp.pop_front();
        check_field("out_id", 8'(e.id), 8'(rsp.out_id));
        check_field("out_valid", 8'(e.vld), 8'(rsp.out_valid));
        check_field("dropped_oldest", 8'(e.drop), 8'(rsp.dropped_oldest));
        check_field("op_error", 8'(e.err), 8'(rsp.op_error));
        check_field("free_count", 8'(e.nfree), 8'(rsp.free_count));
        check_field("queued_count", 8'(e.nqueued), 8'(rsp.queued_count));
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid === 1'b1 && req.ready === 1'b1) ||
        (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("tb_frame_buffer_pool_drop_oldest_core NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    req.valid     = 1'b0;
    req.op        = OP_GET;
    req.buffer_id = '0;
    rsp.ready     = 1'b0;
    src_idle      = 0;
    pool_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(540, 34, 62);
    test_backpressure();
    test_random(540, 62, 34);
    test_random(540, 0, 0);

    repeat (10) @(posedge clk);
    $display("checked %0d of %0d requests: %0d drop-oldest gets, %0d rejected put/store,",
             n_checked, n_sent, n_drop, n_err);
    $display("%0d get/load with no id, plus a %0d-cycle response hold-off", n_none,
             HOLD_CYCLES);
    if (n_fail == 0 && pending_rsp.size() == 0) begin
      $display("tb_frame_buffer_pool_drop_oldest_core OK");
    end else begin
      $display("tb_frame_buffer_pool_drop_oldest_core NOT OK");
    end
    $finish;
  end

endmodule

### frame_buffer_pool_drop_oldest_core.f
hw/rtl/fbp_pkg.sv
hw/rtl/fbp_req_if.sv
hw/rtl/fbp_rsp_if.sv
hw/rtl/fbp_stack_mem.sv
hw/rtl/frame_buffer_pool_drop_oldest_core.sv
tb/tb_frame_buffer_pool_drop_oldest_core.sv
